[hdl/alc_pkg.sv]
`default_nettype none

package alc_pkg;

  localparam int COUNT_W    = 16;  // raw photodiode count
  localparam int LUX_W      = 21;  // result width
  localparam int SCALE_W    = 19;  // scale factor, 2^10 fixed point, times 16 at most
  localparam int SCALE_FRAC = 10;
  localparam int PROD_W     = COUNT_W + SCALE_W;   // raw count times scale
  localparam int CH_W       = PROD_W - SCALE_FRAC; // scaled channel count
  localparam int RATIO_FRAC = 9;
  localparam int DIV_BITS   = RATIO_FRAC + 2;      // quotient bits kept by the divider
  localparam int REM_W      = CH_W + RATIO_FRAC + 1;
  localparam int RATIO_W    = DIV_BITS;
  localparam int COEF_W     = 10;
  localparam int LUX_FRAC   = 14;
  localparam int MUL_W      = CH_W + COEF_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_HIGH  = 1'b1;

  // integration time codes
  localparam logic [1:0] IT_13MS   = 2'd0;
  localparam logic [1:0] IT_101MS  = 2'd1;
  localparam logic [1:0] IT_402MS  = 2'd2;
  localparam logic [1:0] IT_MANUAL = 2'd3;

  localparam logic [SCALE_W-1:0] SCALE_13MS  = 19'h07517;
  localparam logic [SCALE_W-1:0] SCALE_101MS = 19'h00FE7;
  localparam logic [SCALE_W-1:0] SCALE_UNITY = 19'h00400;

  localparam logic [MUL_W:0] ROUND_HALF = (MUL_W + 1)'(1) << (LUX_FRAC - 1);

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [LUX_W-1:0]   lux_t;
  typedef logic [CH_W-1:0]    ch_t;
  typedef logic [RATIO_W-1:0] ratio_t;

  typedef struct packed {
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] slope;
  } coef_t;

  // scale factor from the register settings
  function automatic logic [SCALE_W-1:0] scale_sel(input logic [1:0] it, input logic gain_high);
    logic [SCALE_W-1:0] s;
    unique case (it)
      IT_13MS:  s = SCALE_13MS;
      IT_101MS: s = SCALE_101MS;
      default:  s = SCALE_UNITY;
    endcase
    if (!gain_high) s = s << 4;
    return s;
  endfunction

  // offset and slope of the segment that holds the rounded ratio
  function automatic coef_t seg_lookup(input ratio_t ratio);
    coef_t c;
    priority if (ratio <= 11'h040) c = '{offset: 10'h1f2, slope: 10'h1be};
    else if (ratio <= 11'h080)     c = '{offset: 10'h214, slope: 10'h2d1};
    else if (ratio <= 11'h0c0)     c = '{offset: 10'h23f, slope: 10'h37b};
    else if (ratio <= 11'h100)     c = '{offset: 10'h270, slope: 10'h3fe};
    else if (ratio <= 11'h138)     c = '{offset: 10'h16f, slope: 10'h1fc};
    else if (ratio <= 11'h19a)     c = '{offset: 10'h0d2, slope: 10'h0fb};
    else if (ratio <= 11'h29a)     c = '{offset: 10'h018, slope: 10'h012};
    else                           c = '{offset: '0, slope: '0};
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/alc_sample_if.sv]
`default_nettype none

interface alc_sample_if;
  logic            valid;
  logic            ready;
  alc_pkg::count_t broadband_count;
  alc_pkg::count_t infrared_count;

  modport source (output valid, output broadband_count, output infrared_count, input ready);
  modport sink   (input valid, input broadband_count, input infrared_count, output ready);
endinterface

`default_nettype wire

[hdl/alc_lux_if.sv]
`default_nettype none

interface alc_lux_if;
  logic          valid;
  logic          ready;
  alc_pkg::lux_t vis_lux;
  alc_pkg::lux_t ir_lux;

  modport source (output valid, output vis_lux, output ir_lux, input ready);
  modport sink   (input valid, input vis_lux, input ir_lux, output ready);
endinterface

`default_nettype wire

[hdl/ambient_light_lux_calc.sv]
`default_nettype none

// Two-channel lux calculator. Each item on samples is a broadband/infrared count pair;
// each item on results carries visible and infrared lux, rounded and clamped at zero.
// The block is a 17-stage pipeline: one item enters every cycle unless results stalls
// and the stages fill, and a result leaves when results is ready. Most of that depth is the
// ratio divider, which settles one quotient bit per stage over eleven stages. Every
// stage holds its own valid bit and advances whenever the stage after it is empty or
// moving, so bubbles close up and new items are taken while a result waits.
// integration_time and gain_high are written through cfg_we/cfg_index/cfg_data and
// must only change while the pipeline is empty.
module ambient_light_lux_calc (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [alc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [alc_pkg::CFG_DATA_W-1:0]   cfg_data,
  alc_sample_if.sink                            samples,
  alc_lux_if.source                             results
);

  localparam int NSTG   = 17;               // pipeline depth
  localparam int DV0    = 1;                // divider setup stage
  localparam int SG     = DV0 + alc_pkg::DIV_BITS + 1; // segment select stage
  localparam int MP     = SG + 1;           // products
  localparam int RD     = MP + 1;           // clamp and round
  localparam int OS     = RD + 1;           // output register

  // configuration registers
  logic [1:0] integration_time;
  logic       gain_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      integration_time <= alc_pkg::IT_402MS;
      gain_high        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        alc_pkg::REG_INTEG_TIME: integration_time <= cfg_data[1:0];
        alc_pkg::REG_GAIN_HIGH:  gain_high        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-stage valid bits and the ready chain
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] vin;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] ld;

  assign vin           = {vld[NSTG-2:0], samples.valid};
  assign rdy[NSTG]     = results.ready;
  assign ld            = vin & rdy[NSTG-1:0];
  assign samples.ready = rdy[0];

  for (genvar k = 0; k < NSTG; k++) begin : gen_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) vld[k] <= vin[k];
      end
    end
  end

  // stage 0: scale both counts
  logic [alc_pkg::SCALE_W-1:0] scale;
  logic [alc_pkg::PROD_W-1:0]  prod0;
  logic [alc_pkg::PROD_W-1:0]  prod1;
  alc_pkg::ch_t                s0_ch0;
  alc_pkg::ch_t                s0_ch1;

  assign scale = alc_pkg::scale_sel(integration_time, gain_high);
  assign prod0 = alc_pkg::PROD_W'(samples.broadband_count) * alc_pkg::PROD_W'(scale);
  assign prod1 = alc_pkg::PROD_W'(samples.infrared_count) * alc_pkg::PROD_W'(scale);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_ch0 <= prod0[alc_pkg::PROD_W-1:alc_pkg::SCALE_FRAC];
      s0_ch1 <= prod1[alc_pkg::PROD_W-1:alc_pkg::SCALE_FRAC];
    end
  end

  // divider: index 0 is the setup stage, index j settles quotient bit DIV_BITS-j
  logic [alc_pkg::REM_W-1:0]    dv_rem  [0:alc_pkg::DIV_BITS];
  alc_pkg::ch_t                 dv_d    [0:alc_pkg::DIV_BITS];
  alc_pkg::ch_t                 dv_ch1  [0:alc_pkg::DIV_BITS];
  logic [alc_pkg::DIV_BITS-1:0] dv_q    [0:alc_pkg::DIV_BITS];
  logic                         dv_zero [0:alc_pkg::DIV_BITS];
  logic                         dv_ovf  [0:alc_pkg::DIV_BITS];

  logic [alc_pkg::REM_W:0]      dv_trial [1:alc_pkg::DIV_BITS];

  always_comb begin
    for (int j = 1; j <= alc_pkg::DIV_BITS; j++) begin
      dv_trial[j] = {1'b0, dv_rem[j-1]}
                  - ((alc_pkg::REM_W + 1)'(dv_d[j-1]) << (alc_pkg::DIV_BITS - j));
    end
  end

  always_ff @(posedge clk) begin
    if (ld[DV0]) begin
      dv_rem[0]  <= {s0_ch1, {(alc_pkg::RATIO_FRAC + 1){1'b0}}};
      dv_d[0]    <= s0_ch0;
      dv_ch1[0]  <= s0_ch1;
      dv_q[0]    <= '0;
      dv_zero[0] <= (s0_ch0 == '0);
      // quotient would not fit: ratio far above the last segment
      dv_ovf[0]  <= ({1'b0, s0_ch1} >= {s0_ch0, 1'b0});
    end
    for (int j = 1; j <= alc_pkg::DIV_BITS; j++) begin
      if (ld[DV0+j]) begin
        dv_d[j]    <= dv_d[j-1];
        dv_ch1[j]  <= dv_ch1[j-1];
        dv_zero[j] <= dv_zero[j-1];
        dv_ovf[j]  <= dv_ovf[j-1];
        if (!dv_trial[j][alc_pkg::REM_W]) begin
          dv_rem[j] <= dv_trial[j][alc_pkg::REM_W-1:0];
          dv_q[j]   <= dv_q[j-1]
                     | (alc_pkg::DIV_BITS'(1) << (alc_pkg::DIV_BITS - j));
        end else begin
          dv_rem[j] <= dv_rem[j-1];
          dv_q[j]   <= dv_q[j-1];
        end
      end
    end
  end

  // segment select
  localparam int DL = alc_pkg::DIV_BITS;

  logic [alc_pkg::DIV_BITS:0] q_round;
  alc_pkg::ratio_t            ratio;
  alc_pkg::coef_t             coef_sel;
  alc_pkg::coef_t             sg_coef;
  alc_pkg::ch_t               sg_ch0;
  alc_pkg::ch_t               sg_ch1;

  assign q_round = (alc_pkg::DIV_BITS + 1)'(dv_q[DL]) + 1'b1;
  assign ratio   = q_round[alc_pkg::DIV_BITS:1];

  always_comb begin
    priority if (dv_zero[DL]) coef_sel = alc_pkg::seg_lookup('0);  // no broadband light
    else if (dv_ovf[DL])      coef_sel = '{offset: '0, slope: '0};
    else                      coef_sel = alc_pkg::seg_lookup(ratio);
  end

  always_ff @(posedge clk) begin
    if (ld[SG]) begin
      sg_coef <= coef_sel;
      sg_ch0  <= dv_d[DL];
      sg_ch1  <= dv_ch1[DL];
    end
  end

  // products
  logic [alc_pkg::MUL_W-1:0] mp_vis;
  logic [alc_pkg::MUL_W-1:0] mp_ir;

  always_ff @(posedge clk) begin
    if (ld[MP]) begin
      mp_vis <= alc_pkg::MUL_W'(sg_ch0) * alc_pkg::MUL_W'(sg_coef.offset);
      mp_ir  <= alc_pkg::MUL_W'(sg_ch1) * alc_pkg::MUL_W'(sg_coef.slope);
    end
  end

  // clamp visible at zero, round infrared
  logic [alc_pkg::MUL_W-1:0] rd_vis;
  logic [alc_pkg::MUL_W:0]   rd_ir_sum;

  always_ff @(posedge clk) begin
    if (ld[RD]) begin
      rd_vis    <= (mp_vis > mp_ir) ? (mp_vis - mp_ir) : '0;
      rd_ir_sum <= {1'b0, mp_ir} + alc_pkg::ROUND_HALF;
    end
  end

  // output register
  logic [alc_pkg::MUL_W:0] vis_sum;
  alc_pkg::lux_t           os_vis;
  alc_pkg::lux_t           os_ir;

  assign vis_sum = {1'b0, rd_vis} + alc_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    if (ld[OS]) begin
      os_vis <= vis_sum[alc_pkg::LUX_FRAC +: alc_pkg::LUX_W];
      os_ir  <= rd_ir_sum[alc_pkg::LUX_FRAC +: alc_pkg::LUX_W];
    end
  end

  assign results.valid   = vld[OS];
  assign results.vis_lux = os_vis;
  assign results.ir_lux  = os_ir;

  // a full pipeline that cannot drain must not take a new item
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (vld == '1 && !results.ready) |-> !samples.ready)
    else $error("item accepted into a full, stalled pipeline");

  // last divider stage leaves a remainder below the divisor
  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (vld[DV0+DL] && !dv_zero[DL] && !dv_ovf[DL])
      |-> (dv_rem[DL] < alc_pkg::REM_W'(dv_d[DL])))
    else $error("divider remainder not below divisor");

  // a stalled first stage keeps its item
  a_stage0_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && !rdy[1]) |=> (vld[0] && $stable(s0_ch0) && $stable(s0_ch1)))
    else $error("stalled first stage lost its item");

  // a ratio overflow must select a zero offset and a zero slope
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    (ld[SG] && dv_ovf[DL] && !dv_zero[DL]) |=> (sg_coef.offset == '0 && sg_coef.slope == '0))
    else $error("ratio overflow selected a nonzero segment");

endmodule

`default_nettype wire

[verif/ambient_light_lux_calc_tb.sv]
`timescale 1ns / 100ps

module ambient_light_lux_calc_tb;

  localparam int PIPE_DEPTH = 17;              // depth of the block's pipeline in stages
  localparam int SETTLE     = PIPE_DEPTH + 8;  // quiet time before a register write
  localparam int STALL_MAX  = 4000;            // cycles with no handshake before giving up
  localparam int SEGS       = 7;

  typedef struct packed {
    alc_pkg::count_t broadband;
    alc_pkg::count_t infrared;
  } sample_t;

  typedef struct packed {
    alc_pkg::lux_t visible;
    alc_pkg::lux_t infrared;
  } lux_pair_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [alc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [alc_pkg::CFG_DATA_W-1:0] cfg_data;

  alc_sample_if samples_if ();
  alc_lux_if    results_if ();

  ambient_light_lux_calc u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_if),
    .results   (results_if)
  );

  // segment table: inclusive upper ratio bound (2^9 fixed point), offset and slope
  int unsigned seg_bounds [SEGS] = '{'h040, 'h080, 'h0c0, 'h100, 'h138, 'h19a, 'h29a};
  int unsigned seg_offset [SEGS] = '{'h1f2, 'h214, 'h23f, 'h270, 'h16f, 'h0d2, 'h018};
  int unsigned seg_slope  [SEGS] = '{'h1be, 'h2d1, 'h37b, 'h3fe, 'h1fc, 'h0fb, 'h012};

  // register settings per phase after the first, which runs on reset values
  logic [1:0] it_plan   [SEGS] = '{alc_pkg::IT_13MS, alc_pkg::IT_13MS,
                                   alc_pkg::IT_101MS, alc_pkg::IT_101MS,
                                   alc_pkg::IT_MANUAL, alc_pkg::IT_MANUAL,
                                   alc_pkg::IT_402MS};
  logic       gain_plan [SEGS] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

  // local copy of the block's registers
  logic [1:0] integ_time;
  logic       gain_high_cfg;

  sample_t   sample_q[$];     // items waiting to be driven
  lux_pair_t expected_lux[$]; // predicted results in order
  sample_t   drive_item;

  logic item_taken;   // a sample was accepted at the last rising edge
  logic steady;       // both sides run without idling
  int   mismatches;
  int   stall_cycles;

  always #4 clk = ~clk;

  // exact lux for one count pair under the current register copy
  function automatic lux_pair_t predict_lux(input sample_t s);
    bit [63:0] scale;
    bit [63:0] ch0;
    bit [63:0] ch1;
    bit [63:0] ratio;
    bit [63:0] offset;
    bit [63:0] slope;
    bit [63:0] ir_term;
    bit [63:0] vis_term;
    lux_pair_t r;
    case (integ_time)
      alc_pkg::IT_13MS:  scale = 64'h7517;
      alc_pkg::IT_101MS: scale = 64'h0FE7;
      default:           scale = 64'h0400;  // 402 ms and manual both run unscaled
    endcase
    // 1x gain reads 16 times low
    if (!gain_high_cfg) scale = scale << 4;
    ch0 = (64'(s.broadband) * scale) >> 10;
    ch1 = (64'(s.infrared) * scale) >> 10;
    // ratio to one more fraction bit, then rounded; zero broadband falls in the first segment
    ratio = 0;
    if (ch0 != 0) ratio = (ch1 << 10) / ch0;
    ratio = (ratio + 1) >> 1;
    // above the last bound both terms are zero
    offset = 0;
    slope  = 0;
    for (int k = SEGS - 1; k >= 0; k--) begin
      if (ratio <= seg_bounds[k]) begin
        offset = seg_offset[k];
        slope  = seg_slope[k];
      end
    end
    ir_term  = ch1 * slope;
    vis_term = ch0 * offset;
    // visible clamps at zero before rounding
    r.visible  = (vis_term > ir_term) ?
                 alc_pkg::lux_t'((vis_term - ir_term + 64'd8192) >> 14) : '0;
    r.infrared = alc_pkg::lux_t'((ir_term + 64'd8192) >> 14);
    return r;
  endfunction

  // random count pair, mostly aimed at chosen ratios so every segment gets traffic
  function automatic sample_t rand_sample();
    int unsigned sel;
    int unsigned bb;
    int          ir;
    int unsigned lim;
    sample_t     s;
    sel = $urandom_range(99);
    bb  = $urandom_range(65535);
    if (sel < 30) begin
      // full range on both fields
      ir = $urandom_range(65535);
    end else if (sel < 75) begin
      // ratio spread from zero to past the last segment, magnitudes spread too
      bb = bb >> $urandom_range(12);
      ir = (bb * $urandom_range(720)) / 512;
    end else if (sel < 90) begin
      // just around a segment bound
      lim = seg_bounds[$urandom_range(SEGS - 1)];
      bb  = (bb >> $urandom_range(8)) | 1;
      ir  = (bb * lim) / 512 + $urandom_range(2) - 1;
    end else begin
      // tiny counts, zero broadband included
      bb = $urandom_range(15);
      ir = $urandom_range(15);
    end
    if (ir < 0) ir = 0;
    if (ir > 65535) ir = 65535;
    s.broadband = alc_pkg::count_t'(bb);
    s.infrared  = alc_pkg::count_t'(ir);
    return s;
  endfunction

  // one register write per falling edge
  task automatic write_reg(input logic [alc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [alc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == alc_pkg::REG_INTEG_TIME) integ_time = data;
    else gain_high_cfg = data[0];
  endtask

  // wait until the pipe is empty and settled
  task automatic drain();
    while (sample_q.size() != 0 || samples_if.valid || expected_lux.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // driver: next item goes out at the falling edge once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      samples_if.valid  <= 1'b0;
      results_if.ready  <= 1'b0;
    end else begin
      if (!samples_if.valid || item_taken) begin
        if (sample_q.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
          drive_item = sample_q.pop_front();
          samples_if.valid           <= 1'b1;
          samples_if.broadband_count <= drive_item.broadband;
          samples_if.infrared_count  <= drive_item.infrared;
        end else begin
          samples_if.valid <= 1'b0;
        end
      end
      // receiver stalls on its own schedule
      results_if.ready <= steady || ($urandom_range(99) >= 25);
    end
  end

  // monitor: predict on every accepted sample, check every accepted result
  always @(posedge clk) begin
    if (rst) begin
      item_taken   <= 1'b0;
      stall_cycles <= 0;
    end else begin
      item_taken <= samples_if.valid && samples_if.ready;
      if (samples_if.valid && samples_if.ready)
        expected_lux.push_back(predict_lux('{samples_if.broadband_count,
                                             samples_if.infrared_count}));
      if (results_if.valid && results_if.ready) begin
        if (expected_lux.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result vis_lux %0d ir_lux %0d", $time,
                   results_if.vis_lux, results_if.ir_lux);
        end else begin
          if (results_if.vis_lux !== expected_lux[0].visible) begin
            mismatches++;
            $display("%0t: vis_lux expected %0d got %0d", $time,
                     expected_lux[0].visible, results_if.vis_lux);
          end
          if (results_if.ir_lux !== expected_lux[0].infrared) begin
            mismatches++;
            $display("%0t: ir_lux expected %0d got %0d", $time,
                     expected_lux[0].infrared, results_if.ir_lux);
          end
          void'(expected_lux.pop_front());
        end
      end
      // watchdog on handshake activity
      if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_MAX);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    steady         = 1'b0;
    mismatches     = 0;
    integ_time     = alc_pkg::IT_402MS;  // register values after reset
    gain_high_cfg  = 1'b0;
    samples_if.valid           = 1'b0;
    samples_if.broadband_count = '0;
    samples_if.infrared_count  = '0;
    results_if.ready           = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first phase on reset values: field extremes, zero broadband, every segment bound
    // and one step past it (unit ratio at 512 broadband), then a random batch
    sample_q.push_back('{16'd0, 16'd0});
    sample_q.push_back('{16'hFFFF, 16'hFFFF});
    sample_q.push_back('{16'd0, 16'hFFFF});
    sample_q.push_back('{16'hFFFF, 16'd0});
    sample_q.push_back('{16'd1, 16'd0});
    sample_q.push_back('{16'd0, 16'd1});
    sample_q.push_back('{16'd1, 16'd1});
    for (int k = 0; k < SEGS; k++) begin
      sample_q.push_back('{16'd512, alc_pkg::count_t'(seg_bounds[k])});
      sample_q.push_back('{16'd512, alc_pkg::count_t'(seg_bounds[k] + 1)});
    end
    repeat (40) sample_q.push_back(rand_sample());
    drain();

    // remaining phases: write both registers while idle, then a random batch
    for (int ph = 0; ph < SEGS; ph++) begin
      write_reg(alc_pkg::REG_INTEG_TIME, it_plan[ph]);
      // upper data bit is dropped by the one-bit gain register
      write_reg(alc_pkg::REG_GAIN_HIGH, {1'($urandom_range(1)), gain_plan[ph]});
      @(negedge clk);
      cfg_we <= 1'b0;
      // one phase runs with no idling on either side
      steady = (ph == 3);
      repeat (66) sample_q.push_back(rand_sample());
      drain();
    end

    if (mismatches == 0 && expected_lux.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
